@@ sv/fdtw_pkg.sv @@
// fdtw_pkg: shared constants, codes and types of the devicetree structure walker
// no dependencies; used by every module of the walker
package fdtw_pkg;

  localparam int MAX_PATH_LEN  = 256;
  localparam int PATH_BITS     = $clog2(MAX_PATH_LEN);
  localparam int ROW_BITS      = PATH_BITS - 2;
  localparam int ROWS          = MAX_PATH_LEN / 4;
  localparam int POSITION_BITS = 24;
  localparam int DEPTH_BITS    = 8;
  localparam int STACK_DEPTH   = 1 << DEPTH_BITS;
  localparam int OUT_DEPTH     = 4;
  localparam int OUT_PTR_BITS  = $clog2(OUT_DEPTH);

  localparam logic [31:0] FDT_MAGIC = 32'hd00dfeed;

  // input commands
  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_WORD  = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // structure tokens
  localparam logic [31:0] TOK_BEGIN_NODE = 32'd1;
  localparam logic [31:0] TOK_END_NODE   = 32'd2;
  localparam logic [31:0] TOK_PROP       = 32'd3;
  localparam logic [31:0] TOK_END        = 32'd9;

  // result kinds
  localparam logic [2:0] RK_STARTED   = 3'd0;
  localparam logic [2:0] RK_BAD_MAGIC = 3'd1;
  localparam logic [2:0] RK_PROPERTY  = 3'd2;
  localparam logic [2:0] RK_END_OK    = 3'd3;
  localparam logic [2:0] RK_OVERFLOW  = 3'd4;
  localparam logic [2:0] RK_UNBAL     = 3'd5;
  localparam logic [2:0] RK_OPEN_END  = 3'd6;
  localparam logic [2:0] RK_PATH_BYTE = 3'd7;

  // walk phases
  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_TOKEN = 3'd1;
  localparam logic [2:0] PH_NAME  = 3'd2;
  localparam logic [2:0] PH_PLEN  = 3'd3;
  localparam logic [2:0] PH_POFF  = 3'd4;
  localparam logic [2:0] PH_SKIP  = 3'd5;
  localparam logic [2:0] PH_HALT  = 3'd6;

  typedef enum logic [2:0] {
    OP_START_OK,
    OP_START_BAD,
    OP_WORD,
    OP_READ,
    OP_NONE
  } op_e;

  // classified request from the front to the back
  typedef struct packed {
    op_e                  op;
    logic                 tok_begin;
    logic                 tok_end_node;
    logic                 tok_prop;
    logic                 tok_end;
    logic [31:0]          word;
    logic [PATH_BITS-1:0] index;
  } item_t;

  typedef struct packed {
    logic [2:0]               kind;
    logic [31:0]              size;
    logic [31:0]              noff;
    logic [POSITION_BITS-1:0] doff;
    logic [7:0]               depth;
    logic [7:0]               plen;
    logic [7:0]               pbyte;
  } result_t;

endpackage

@@ sv/fdtw_front.sv @@
// fdtw_front: accepts requests, decodes command and token, holds them in a short queue
// depends on fdtw_pkg
module fdtw_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             push,
  output logic                             full,
  input  logic [1:0]                       cmd_i,
  input  logic [31:0]                      word_i,
  input  logic [fdtw_pkg::PATH_BITS-1:0]   path_index_i,
  output logic                             q_valid_o,
  output fdtw_pkg::item_t                  q_item_o,
  input  logic                             q_pop_i
);

  fdtw_pkg::item_t ent_q [2];
  fdtw_pkg::item_t cls;
  logic            wr_ptr_q, rd_ptr_q;
  logic [1:0]      cnt_q;
  logic            do_push;

  // classify the incoming request
  always_comb begin
    cls              = '0;
    cls.word         = word_i;
    cls.index        = path_index_i;
    cls.tok_begin    = (word_i == fdtw_pkg::TOK_BEGIN_NODE);
    cls.tok_end_node = (word_i == fdtw_pkg::TOK_END_NODE);
    cls.tok_prop     = (word_i == fdtw_pkg::TOK_PROP);
    cls.tok_end      = (word_i == fdtw_pkg::TOK_END);
    unique case (cmd_i)
      fdtw_pkg::CMD_START: begin
        cls.op = (word_i == fdtw_pkg::FDT_MAGIC) ? fdtw_pkg::OP_START_OK
                                                 : fdtw_pkg::OP_START_BAD;
      end
      fdtw_pkg::CMD_WORD: cls.op = fdtw_pkg::OP_WORD;
      fdtw_pkg::CMD_READ: cls.op = fdtw_pkg::OP_READ;
      default:            cls.op = fdtw_pkg::OP_NONE;
    endcase
  end

  assign full      = (cnt_q == 2'd2);
  assign do_push   = push && !full;
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_item_o  = ent_q[rd_ptr_q];

  // two-entry queue storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      ent_q[wr_ptr_q] <= cls;
    end
  end

  // queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= ~wr_ptr_q;
      if (q_pop_i) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, q_pop_i};
    end
  end

endmodule

@@ sv/fdtw_back.sv @@
// fdtw_back: carries out classified requests, keeps the path store and the length stack
// depends on fdtw_pkg
module fdtw_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_valid_i,
  input  fdtw_pkg::item_t       q_item_i,
  output logic                  q_pop_o,
  input  logic                  room_i,
  output logic                  res_valid_o,
  output fdtw_pkg::result_t     res_o
);

  localparam int PB = fdtw_pkg::PATH_BITS;
  localparam int DB = fdtw_pkg::DEPTH_BITS;
  localparam int RB = fdtw_pkg::ROW_BITS;
  localparam int PS = fdtw_pkg::POSITION_BITS;

  // walk state
  logic [2:0]    phase_q, phase_d;
  logic [PB-1:0] plen_q, plen_d;
  logic [DB-1:0] depth_q, depth_d;
  logic [PS-1:0] pos_q, pos_d;
  logic [30:0]   skip_q, skip_d;
  logic [31:0]   psize_q, psize_d;
  logic [PB-1:0] top_q, top_d, below_q, below_d, rd_q;

  // path store banks, one byte lane per address low bits
  logic [7:0]    bank_mem [4][fdtw_pkg::ROWS];
  logic [7:0]    rdata_q [4];
  logic [1:0]    rsel_q;

  // length stack memory, holds the entries spilled from the cached top, below included
  logic [PB-1:0] stack_mem [fdtw_pkg::STACK_DEPTH];
  logic          st_we;

  logic          fire, emit;
  fdtw_pkg::result_t res_d, s2_q;
  logic          s2_valid_q;

  // name byte handling
  logic [7:0]    nb [4];
  logic [4:0]    cont;
  logic [PB:0]   naddr [4];
  logic [3:0]    nwr;
  logic          novf;
  logic [2:0]    ncnt;
  logic [3:0]    bwe;
  logic [RB-1:0] brow [4];
  logic [7:0]    bdata [4];
  logic [1:0]    bj [4];
  logic [32:0]   skip_sum;

  assign fire    = q_valid_i && room_i;
  assign q_pop_o = fire;

  // per-byte append decisions for a name word
  always_comb begin
    cont[0] = 1'b1;
    novf    = 1'b0;
    ncnt    = 3'd0;
    for (int j = 0; j < 4; j++) begin
      nb[j]      = q_item_i.word[31-8*j -: 8];
      cont[j+1]  = cont[j] && (nb[j] != 8'd0);
      naddr[j]   = {1'b0, plen_q} + (PB+1)'(j);
      nwr[j]     = cont[j] && (naddr[j] < (PB+1)'(fdtw_pkg::MAX_PATH_LEN - 1));
      novf       = novf || (cont[j] && !nwr[j]);
      ncnt       = ncnt + {2'b0, nwr[j]};
    end
    for (int k = 0; k < 4; k++) begin
      bj[k]    = 2'(k) - plen_q[1:0];
      bwe[k]   = fire && (q_item_i.op == fdtw_pkg::OP_WORD) && (phase_q == fdtw_pkg::PH_NAME)
                 && nwr[bj[k]];
      brow[k]  = naddr[bj[k]][PB-1:2];
      bdata[k] = (nb[bj[k]] == 8'd0) ? 8'h2f : nb[bj[k]];
    end
  end

  assign skip_sum = {1'b0, psize_q} + 33'd3;

  // request execution
  always_comb begin
    phase_d = phase_q;
    plen_d  = plen_q;
    depth_d = depth_q;
    pos_d   = pos_q;
    skip_d  = skip_q;
    psize_d = psize_q;
    top_d   = top_q;
    below_d = below_q;
    st_we   = 1'b0;
    emit    = 1'b0;
    res_d   = '0;
    if (fire) begin
      unique case (q_item_i.op)
        fdtw_pkg::OP_START_BAD: begin
          phase_d    = fdtw_pkg::PH_IDLE;
          emit       = 1'b1;
          res_d.kind = fdtw_pkg::RK_BAD_MAGIC;
        end
        fdtw_pkg::OP_START_OK: begin
          phase_d    = fdtw_pkg::PH_TOKEN;
          plen_d     = '0;
          depth_d    = '0;
          pos_d      = '0;
          skip_d     = '0;
          psize_d    = '0;
          emit       = 1'b1;
          res_d.kind = fdtw_pkg::RK_STARTED;
        end
        fdtw_pkg::OP_READ: begin
          emit       = 1'b1;
          res_d.kind = fdtw_pkg::RK_PATH_BYTE;
        end
        fdtw_pkg::OP_WORD: begin
          if (phase_q != fdtw_pkg::PH_IDLE && phase_q != fdtw_pkg::PH_HALT) begin
            pos_d = pos_q + PS'(1);
            unique case (phase_q)
              fdtw_pkg::PH_TOKEN: begin
                priority if (q_item_i.tok_begin) begin
                  st_we   = (depth_q != '0);
                  below_d = top_q;
                  top_d   = plen_q;
                  depth_d = depth_q + DB'(1);
                  phase_d = fdtw_pkg::PH_NAME;
                end else if (q_item_i.tok_end_node) begin
                  if (depth_q == '0) begin
                    phase_d    = fdtw_pkg::PH_HALT;
                    emit       = 1'b1;
                    res_d.kind = fdtw_pkg::RK_UNBAL;
                  end else begin
                    depth_d = depth_q - DB'(1);
                    plen_d  = top_q;
                    top_d   = below_q;
                    below_d = rd_q;
                  end
                end else if (q_item_i.tok_prop) begin
                  phase_d = fdtw_pkg::PH_PLEN;
                end else if (q_item_i.tok_end) begin
                  phase_d    = fdtw_pkg::PH_HALT;
                  emit       = 1'b1;
                  res_d.kind = (depth_q == '0) ? fdtw_pkg::RK_END_OK : fdtw_pkg::RK_OPEN_END;
                end else begin
                  phase_d = phase_q;
                end
              end
              fdtw_pkg::PH_NAME: begin
                plen_d = plen_q + PB'(ncnt);
                if (novf) begin
                  phase_d    = fdtw_pkg::PH_HALT;
                  emit       = 1'b1;
                  res_d.kind = fdtw_pkg::RK_OVERFLOW;
                end else if (!cont[4]) begin
                  phase_d = fdtw_pkg::PH_TOKEN;
                end
              end
              fdtw_pkg::PH_PLEN: begin
                psize_d = q_item_i.word;
                phase_d = fdtw_pkg::PH_POFF;
              end
              fdtw_pkg::PH_POFF: begin
                skip_d     = skip_sum[32:2];
                phase_d    = (skip_sum[32:2] != 31'd0) ? fdtw_pkg::PH_SKIP : fdtw_pkg::PH_TOKEN;
                emit       = 1'b1;
                res_d.kind = fdtw_pkg::RK_PROPERTY;
                res_d.size = psize_q;
                res_d.noff = q_item_i.word;
                res_d.doff = pos_d;
              end
              fdtw_pkg::PH_SKIP: begin
                if (skip_q != 31'd0) skip_d = skip_q - 31'd1;
                if (skip_q <= 31'd1) phase_d = fdtw_pkg::PH_TOKEN;
              end
              default: phase_d = fdtw_pkg::PH_HALT;
            endcase
          end
        end
        default: phase_d = phase_q;
      endcase
    end
    res_d.depth = 8'(depth_d);
    res_d.plen  = 8'(plen_d);
  end

  // path store writes and registered read
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 4; k++) begin
      if (bwe[k]) bank_mem[k][brow[k]] <= bdata[k];
      rdata_q[k] <= bank_mem[k][q_item_i.index[PB-1:2]];
    end
    rsel_q <= q_item_i.index[1:0];
  end

  // length stack: push spills old top, read keeps the third entry ready
  always_ff @(posedge clk_i) begin
    if (st_we) stack_mem[depth_q - DB'(1)] <= top_q;
    rd_q <= stack_mem[depth_d - DB'(3)];
  end

  // result stage payload
  always_ff @(posedge clk_i) begin
    if (emit) s2_q <= res_d;
    top_q   <= top_d;
    below_q <= below_d;
  end

  // walk control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= fdtw_pkg::PH_IDLE;
      plen_q     <= '0;
      depth_q    <= '0;
      pos_q      <= '0;
      skip_q     <= '0;
      psize_q    <= '0;
      s2_valid_q <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      plen_q     <= plen_d;
      depth_q    <= depth_d;
      pos_q      <= pos_d;
      skip_q     <= skip_d;
      psize_q    <= psize_d;
      s2_valid_q <= emit;
    end
  end

  // path byte joins the result after the registered read
  always_comb begin
    res_o = s2_q;
    res_o.pbyte = (s2_q.kind == fdtw_pkg::RK_PATH_BYTE) ? rdata_q[rsel_q] : 8'd0;
  end
  assign res_valid_o = s2_valid_q;

endmodule

@@ sv/fdtw_result_fifo.sv @@
// fdtw_result_fifo: small result queue toward the consumer
// depends on fdtw_pkg
module fdtw_result_fifo (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                wr_i,
  input  fdtw_pkg::result_t                   wr_data_i,
  input  logic                                inflight_i,
  output logic                                room_o,
  output logic                                empty,
  input  logic                                pop,
  output fdtw_pkg::result_t                   head_o
);

  localparam int PW = fdtw_pkg::OUT_PTR_BITS;

  fdtw_pkg::result_t   mem_q [fdtw_pkg::OUT_DEPTH];
  logic [PW-1:0]       wr_ptr_q, rd_ptr_q;
  logic [PW:0]         cnt_q;
  logic                do_pop;

  assign empty  = (cnt_q == '0);
  assign do_pop = pop && !empty;
  assign head_o = mem_q[rd_ptr_q];
  // room counts the result still in flight
  assign room_o = ((cnt_q + {{PW{1'b0}}, inflight_i}) < (PW+1)'(fdtw_pkg::OUT_DEPTH));

  // storage
  always_ff @(posedge clk_i) begin
    if (wr_i) mem_q[wr_ptr_q] <= wr_data_i;
  end

  // pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr_i)   wr_ptr_q <= wr_ptr_q + PW'(1);
      if (do_pop) rd_ptr_q <= rd_ptr_q + PW'(1);
      cnt_q <= cnt_q + {{PW{1'b0}}, wr_i} - {{PW{1'b0}}, do_pop};
    end
  end

endmodule

@@ sv/fdt_structure_walker_core.sv @@
// fdt_structure_walker_core: top level of the devicetree structure walker
// depends on fdtw_pkg, fdtw_front, fdtw_back, fdtw_result_fifo
//
//   channel  | handshake       | fields
//   request  | push / full     | cmd_i, word_i, path_index_i
//   result   | empty / pop     | result_kind_o .. path_byte_o
//
// one request per cycle sustained while the result queue has room; a result passes the
// request queue, the execute stage with its path store read register and the result queue.
// full rises when the two-entry request queue fills; the back stalls only when
// the four-entry result queue has no room, so bursts ride through short pops.
// reset clears control state; the path store and length stack need no clearing.
module fdt_structure_walker_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  cmd_i,
  input  logic [31:0] word_i,
  input  logic [7:0]  path_index_i,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  result_kind_o,
  output logic [31:0] prop_size_o,
  output logic [31:0] name_off_o,
  output logic [23:0] data_offset_o,
  output logic [7:0]  depth_o,
  output logic [7:0]  path_len_o,
  output logic [7:0]  path_byte_o
);

  logic              q_valid, q_pop, room, res_valid;
  fdtw_pkg::item_t   q_item;
  fdtw_pkg::result_t res, head;

  // request decode and queue
  fdtw_front u_front (
    .clk_i, .rst_ni, .push, .full, .cmd_i, .word_i, .path_index_i,
    .q_valid_o (q_valid),
    .q_item_o  (q_item),
    .q_pop_i   (q_pop)
  );

  // execution
  fdtw_back u_back (
    .clk_i, .rst_ni,
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .room_i      (room),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // result queue
  fdtw_result_fifo u_out (
    .clk_i, .rst_ni,
    .wr_i       (res_valid),
    .wr_data_i  (res),
    .inflight_i (res_valid),
    .room_o     (room),
    .empty,
    .pop,
    .head_o     (head)
  );

  assign result_kind_o = head.kind;
  assign prop_size_o   = head.size;
  assign name_off_o    = head.noff;
  assign data_offset_o = head.doff;
  assign depth_o       = head.depth;
  assign path_len_o    = head.plen;
  assign path_byte_o   = head.pbyte;

endmodule
